// ----- sv/bsp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared constants for the batched servo pulse generator: opcodes, field
// widths, beat layouts and the register map.
// ----------------------------------------------------------------------------
package bsp_pkg;

	// Item opcodes carried on s_axis_tuser
	localparam int OPCODE_W = 2;
	localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_WRITE  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_ACTIVE = 2'd2;

	// Field widths
	localparam int IDX_W       = 8;
	localparam int WIDTH_W     = 16;
	localparam int PIN_W       = 12;
	localparam int BATCH_OUT_W = 2;

	// Beat layouts
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 16;
	localparam int M_PIN_LSB  = 0;
	localparam int M_BATCH_LSB = 12;
	localparam int M_RUN_BIT  = 14;

	// Register map (word index = paddr[APB_ADDR_W-1:2])
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_PERIOD = 1'b0;
	localparam logic [WIDTH_W-1:0] PERIOD_RESET = 16'd3000;

endpackage

// ----- sv/bsp_width_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_width_ram
// Pulse-width table: one row per batch, one 16-bit word per lane. Single
// lane write, registered whole row read. Per-entry valid bits make
// unwritten entries read as zero.
// ----------------------------------------------------------------------------
module bsp_width_ram import bsp_pkg::*; #(
	parameter int ROWS  = 3,
	parameter int LANES = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0]   wr_row,
	input  logic [(LANES > 1 ? $clog2(LANES) : 1)-1:0] wr_lane,
	input  logic [WIDTH_W-1:0]              wr_data,
	input  logic                            rd_en,
	input  logic [(ROWS > 1 ? $clog2(ROWS) : 1)-1:0]   rd_row,
	output logic [LANES-1:0][WIDTH_W-1:0]   rd_data
);

	localparam int ENTRIES = ROWS * LANES;
	localparam int VW = ENTRIES > 1 ? $clog2(ENTRIES) : 1;

	logic [LANES-1:0][WIDTH_W-1:0] mem [ROWS];
	logic [ENTRIES-1:0]            valid_q;
	logic [LANES-1:0][WIDTH_W-1:0] rd_q;
	logic [LANES-1:0]              rd_valid_q;
	logic [VW-1:0]                 wr_vidx;

	assign wr_vidx = VW'(wr_row * LANES) + VW'(wr_lane);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row][wr_lane] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= '0;
		end else begin
			if (wr_en) begin
				valid_q[wr_vidx] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_row * LANES +: LANES];
			end
		end
	end

	// Drop words never written
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			rd_data[l] = rd_valid_q[l] ? rd_q[l] : '0;
		end
	end

endmodule

// ----- sv/batched_servo_pulse_generator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batched_servo_pulse_generator_unit
// Multiplexed servo PWM: SERVOS pins driven LANES at a time, one batch per
// timer slot of period_ticks ticks. Items are ticks, width writes and
// run/stop commands; every item returns one beat with the pin levels.
// ----------------------------------------------------------------------------
// Flow: an accepted item moves into stage 1, then into the output register,
//   which hands the result beat over when the sink takes it.
// Throughput: one item per cycle while the sink does not stall; the tick
//   counter compare/increment loop sits in the accept stage, and the width
//   table row read for a batch latch is registered and ready for stage 1.
// Reset (arst_n low, asynchronous): halted, counter and batch zero, all pins
//   low, width table reads zero, period_ticks = 3000. No clearing pass.
// ----------------------------------------------------------------------------
module batched_servo_pulse_generator_unit import bsp_pkg::*; #(
	parameter int SERVOS = 12,
	parameter int LANES  = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,

	// Item stream in
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [7:0] servo_index, [23:8] pulse_width, [24] active, [31:25] zero
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,
	// [1:0] opcode
	input  logic [OPCODE_W-1:0]   s_axis_tuser,

	// Result stream out
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [11:0] pin_levels, [13:12] current_batch, [14] is_running, [15] zero
	output logic [M_TDATA_W-1:0]  m_axis_tdata,

	// Configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int NBATCH = (SERVOS + LANES - 1) / LANES;
	localparam int BW     = NBATCH > 1 ? $clog2(NBATCH) : 1;
	localparam int LW     = LANES > 1 ? $clog2(LANES) : 1;
	// Reciprocal of LANES in 16-bit fixed point; exact quotient for 8-bit index
	localparam int RECIP  = (65536 + LANES - 1) / LANES;
	localparam int PROD_W = IDX_W + 17;

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [WIDTH_W-1:0] period_q;
	logic               cfg_sel;

	assign pready  = 1'b1;
	assign cfg_sel = (paddr[APB_ADDR_W-1:2] == REG_PERIOD);
	assign prdata  = cfg_sel ? APB_DATA_W'(period_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (psel && penable && pwrite && pready && cfg_sel) begin
			period_q <= pwdata[WIDTH_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Input unpacking
	// ------------------------------------------------------------------
	logic [OPCODE_W-1:0] opcode;
	logic [IDX_W-1:0]    servo_index;
	logic [WIDTH_W-1:0]  pulse_width;
	logic                active;

	assign opcode      = s_axis_tuser;
	assign servo_index = s_axis_tdata[IDX_W-1:0];
	assign pulse_width = s_axis_tdata[IDX_W +: WIDTH_W];
	assign active      = s_axis_tdata[IDX_W + WIDTH_W];

	// ------------------------------------------------------------------
	// Stage 0: control state update at accept
	// The counter, batch and run flag live here so that back-to-back
	// ticks see each other's effect with no bubble.
	// ------------------------------------------------------------------
	logic               accept;
	logic               advance;
	logic               s1_valid_q;

	logic [WIDTH_W-1:0] cnt_q, cnt_d;
	logic [BW-1:0]      batch_q, batch_d;
	logic               run_q, run_d;
	logic               latch_d, lower_d, clear_d;
	logic [WIDTH_W-1:0] limit;
	logic               wrap;
	logic               last_batch;

	assign advance       = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = !s1_valid_q || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Period of 0 or 1 wraps on every tick
	assign limit      = (period_q != '0) ? period_q - WIDTH_W'(1) : '0;
	assign wrap       = (cnt_q >= limit);
	assign last_batch = (batch_q == BW'(NBATCH - 1));

	always_comb begin
		cnt_d   = cnt_q;
		batch_d = batch_q;
		run_d   = run_q;
		latch_d = 1'b0;
		lower_d = 1'b0;
		clear_d = 1'b0;
		unique case (opcode)
			OP_TICK: begin
				if (run_q) begin
					if (wrap) begin
						cnt_d   = '0;
						batch_d = last_batch ? '0 : batch_q + BW'(1);
						latch_d = 1'b1;
					end else begin
						cnt_d   = cnt_q + WIDTH_W'(1);
						lower_d = 1'b1;
					end
				end
			end
			OP_ACTIVE: begin
				if (active && !run_q) begin
					run_d   = 1'b1;
					cnt_d   = '0;
					batch_d = '0;
					latch_d = 1'b1;
				end else if (!active && run_q) begin
					run_d   = 1'b0;
					clear_d = 1'b1;
				end
			end
			default: begin
				// Width writes go straight to the table; unused opcode is ignored
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			batch_q <= '0;
			run_q   <= 1'b0;
		end else if (accept) begin
			cnt_q   <= cnt_d;
			batch_q <= batch_d;
			run_q   <= run_d;
		end
	end

	// ------------------------------------------------------------------
	// Width table write: split servo index into row (batch) and lane
	// ------------------------------------------------------------------
	logic [PROD_W-1:0] idx_prod;
	logic [IDX_W:0]    idx_quot;
	logic [IDX_W-1:0]  idx_rem;
	logic              idx_ok;
	logic              wr_en;
	logic [BW-1:0]     wr_row;
	logic [LW-1:0]     wr_lane;

	assign idx_prod = PROD_W'(servo_index) * PROD_W'(RECIP);
	assign idx_quot = idx_prod[16 +: IDX_W + 1];
	assign idx_rem  = servo_index - IDX_W'(idx_quot * LANES);
	assign idx_ok   = (IDX_W + 1)'(servo_index) < (IDX_W + 1)'(SERVOS);
	assign wr_row   = idx_quot[BW-1:0];
	assign wr_lane  = idx_rem[LW-1:0];
	assign wr_en    = accept && (opcode == OP_WRITE) && idx_ok;

	logic [LANES-1:0][WIDTH_W-1:0] row_data;

	bsp_width_ram #(
		.ROWS  (NBATCH),
		.LANES (LANES)
	) u_width_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_row  (wr_row),
		.wr_lane (wr_lane),
		.wr_data (pulse_width),
		.rd_en   (accept && latch_d),
		.rd_row  (batch_d),
		.rd_data (row_data)
	);

	// ------------------------------------------------------------------
	// Stage 1: lane compares and pin register, fed by the table row
	// ------------------------------------------------------------------
	logic               latch_s1, lower_s1, clear_s1, run_s1;
	logic [WIDTH_W-1:0] cnt_s1;
	logic [BW-1:0]      batch_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			latch_s1   <= 1'b0;
			lower_s1   <= 1'b0;
			clear_s1   <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= accept;
			latch_s1   <= latch_d;
			lower_s1   <= lower_d;
			clear_s1   <= clear_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_s1   <= cnt_d;
			batch_s1 <= batch_d;
			run_s1   <= run_d;
		end
	end

	logic [LANES-1:0][WIDTH_W-1:0] cmp_q, cmp_d;
	logic [SERVOS-1:0]             pin_q, pin_d;
	logic                          move;

	assign move = s1_valid_q && advance;

	always_comb begin
		cmp_d = cmp_q;
		pin_d = pin_q;
		if (latch_s1) begin
			cmp_d = row_data;
		end
		if (clear_s1) begin
			pin_d = '0;
		end else if (latch_s1) begin
			// Raise the new batch's pins whose width is nonzero
			for (int s = 0; s < SERVOS; s++) begin
				if (BW'(s / LANES) == batch_s1 && row_data[s % LANES] != '0) begin
					pin_d[s] = 1'b1;
				end
			end
		end else if (lower_s1) begin
			// Lower a pin when its lane matches the counter; zero never matches
			for (int s = 0; s < SERVOS; s++) begin
				if (BW'(s / LANES) == batch_s1 && cmp_q[s % LANES] != '0
						&& cmp_q[s % LANES] == cnt_s1) begin
					pin_d[s] = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_q <= '0;
			pin_q <= '0;
		end else if (move) begin
			cmp_q <= cmp_d;
			pin_q <= pin_d;
		end
	end

	// ------------------------------------------------------------------
	// Output register: holds the result beat while the sink stalls
	// ------------------------------------------------------------------
	logic [PIN_W-1:0]       pins_out;
	logic [BATCH_OUT_W-1:0] batch_out;

	generate
		if (SERVOS >= PIN_W) begin : g_pins_trunc
			assign pins_out = pin_d[PIN_W-1:0];
		end else begin : g_pins_ext
			assign pins_out = {{(PIN_W - SERVOS){1'b0}}, pin_d};
		end
		if (BW >= BATCH_OUT_W) begin : g_batch_trunc
			assign batch_out = batch_s1[BATCH_OUT_W-1:0];
		end else begin : g_batch_ext
			assign batch_out = {{(BATCH_OUT_W - BW){1'b0}}, batch_s1};
		end
	endgenerate

	logic                   out_valid_q;
	logic [PIN_W-1:0]       out_pins_q;
	logic [BATCH_OUT_W-1:0] out_batch_q;
	logic                   out_run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_pins_q  <= pins_out;
			out_batch_q <= batch_out;
			out_run_q   <= run_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_run_q, out_batch_q, out_pins_q};

endmodule

// ----- sv/bsp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_checker
// Port-level checks for the batched servo pulse generator, bound to the
// top level.
// ----------------------------------------------------------------------------
module bsp_checker import bsp_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata
);

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// With the output register empty the block always takes an item
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// All pins are low whenever generation is halted
	a_halt_pins_low: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[M_RUN_BIT]
			|-> m_axis_tdata[M_PIN_LSB +: PIN_W] == '0)
		else $error("pin high while halted");

	// An accepted item with a free sink shows a result beat after passing stage 1
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && m_axis_tready |=> ##1 m_axis_tvalid)
		else $error("result beat missing");

endmodule

bind batched_servo_pulse_generator_unit bsp_checker u_bsp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ----- tb/batched_servo_pulse_generator_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batched_servo_pulse_generator_unit_tb
// Self-checking bench for the batched servo pulse generator. A class keeps a
// cycle-free model of the width table, lane compares, tick counter and pins,
// predicts one result beat per accepted item and checks every output beat
// against it. Ticks, width writes, run/stop commands and the spare opcode are
// driven under several period settings and sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module batched_servo_pulse_generator_unit_tb;
	import bsp_pkg::*;

	localparam int SERVOS = 12;
	localparam int LANES  = 4;

	// Opcode 3 has no function; the block must ignore it
	localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

	// Cycles with no beat on any port before the run is declared hung
	localparam int QUIET_LIMIT = 2000;

	// Period settings, one per random phase: the extremes, the wrap-every-tick
	// values 0 and 1, and a few small ones so that pulses end inside a slot
	localparam int NUM_PHASES = 8;
	localparam int unsigned PERIOD_PLAN [NUM_PHASES] =
		'{2, 9, 1, 65534, 0, 25, 6, 3000};
	localparam int ITEMS_PER_PHASE = 150;

	typedef struct {
		logic [OPCODE_W-1:0] opcode;
		logic [IDX_W-1:0]    servo_index;
		logic [WIDTH_W-1:0]  pulse_width;
		logic                active;
	} servo_item_t;

	typedef struct {
		logic [PIN_W-1:0]       pin_levels;
		logic [BATCH_OUT_W-1:0] current_batch;
		logic                   is_running;
	} pin_state_t;

	// ------------------------------------------------------------------------
	// Pin level predictor and queue of expected result beats
	// ------------------------------------------------------------------------
	class pin_level_predictor;
		bit [15:0]    period_ticks;
		bit [15:0]    width_table [SERVOS];
		bit [15:0]    lane_cmp [LANES];
		bit [15:0]    tick_count;
		int unsigned  batch_no;
		bit           running;
		bit [PIN_W-1:0] pins;
		pin_state_t   pending_levels [$];
		int           mismatches;
		int           beats_checked;
		int           items_taken;
		int           running_ticks;
		int           batch_changes;
		int           pin_falls;

		function new();
			period_ticks = PERIOD_RESET;
			foreach (width_table[i]) width_table[i] = '0;
			foreach (lane_cmp[i]) lane_cmp[i] = '0;
			tick_count = '0;
			batch_no = 0;
			running = 1'b0;
			pins = '0;
			mismatches = 0;
			beats_checked = 0;
			items_taken = 0;
			running_ticks = 0;
			batch_changes = 0;
			pin_falls = 0;
		endfunction

		// Copy the batch's widths into the lanes and raise nonzero ones
		function void latch_lanes();
			int s;
			for (int lane = 0; lane < LANES; lane++) begin
				s = batch_no * LANES + lane;
				lane_cmp[lane] = (s < SERVOS) ? width_table[s] : 16'd0;
				if (lane_cmp[lane] != 0)
					pins[s] = 1'b1;
			end
		endfunction

		function void advance_tick();
			int unsigned last_count;
			int s;
			last_count = (period_ticks != 0) ? period_ticks - 1 : 0;
			running_ticks++;
			if (tick_count >= last_count) begin
				tick_count = '0;
				batch_no = ((batch_no + 1) * LANES >= SERVOS) ? 0 : batch_no + 1;
				batch_changes++;
				latch_lanes();
			end else begin
				tick_count = tick_count + 16'd1;
				for (int lane = 0; lane < LANES; lane++) begin
					s = batch_no * LANES + lane;
					if (lane_cmp[lane] != 0 && lane_cmp[lane] == tick_count && s < SERVOS) begin
						if (pins[s])
							pin_falls++;
						pins[s] = 1'b0;
					end
				end
			end
		endfunction

		function void set_period(bit [15:0] value);
			period_ticks = value;
		endfunction

		// Apply one accepted item and queue the beat it must produce
		function void note_item(servo_item_t it);
			pin_state_t want;
			items_taken++;
			case (it.opcode)
				OP_TICK: begin
					if (running)
						advance_tick();
				end
				OP_WRITE: begin
					if (it.servo_index < SERVOS)
						width_table[it.servo_index] = it.pulse_width;
				end
				OP_ACTIVE: begin
					if (it.active && !running) begin
						running = 1'b1;
						tick_count = '0;
						batch_no = 0;
						latch_lanes();
					end else if (!it.active && running) begin
						running = 1'b0;
						pins = '0;
					end
				end
				default: ;
			endcase
			want.pin_levels    = pins;
			want.current_batch = batch_no[BATCH_OUT_W-1:0];
			want.is_running    = running;
			pending_levels.push_back(want);
		endfunction

		task report(string what, int got, int want);
			mismatches++;
			$display("[%0t] MISMATCH beat %0d: %s got 0x%0h, expected 0x%0h",
				$time, beats_checked, what, got, want);
		endtask

		task check_beat(logic [M_TDATA_W-1:0] data);
			pin_state_t want;
			if (pending_levels.size() == 0) begin
				report("unexpected beat, data", data, 0);
			end else begin
				want = pending_levels.pop_front();
				if (data[M_PIN_LSB +: PIN_W] !== want.pin_levels)
					report("pin_levels", data[M_PIN_LSB +: PIN_W], want.pin_levels);
				if (data[M_BATCH_LSB +: BATCH_OUT_W] !== want.current_batch)
					report("current_batch", data[M_BATCH_LSB +: BATCH_OUT_W],
						want.current_batch);
				if (data[M_RUN_BIT] !== want.is_running)
					report("is_running", data[M_RUN_BIT], want.is_running);
			end
			beats_checked++;
		endtask
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and block ports
	// ------------------------------------------------------------------------
	logic clk;
	logic arst_n = 1'b0;

	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// [7:0] servo_index, [23:8] pulse_width, [24] active, [31:25] zero
	logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
	// [1:0] opcode
	logic [OPCODE_W-1:0]   s_axis_tuser = OP_TICK;

	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// [11:0] pin_levels, [13:12] current_batch, [14] is_running, [15] zero
	logic [M_TDATA_W-1:0]  m_axis_tdata;

	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// Percent of cycles in which the sender holds off / the receiver stalls
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	pin_level_predictor levels;

	batched_servo_pulse_generator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Receiver: drop tready at random according to the current stall rate
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Check every result beat the block hands over; values seen here are the
	// ones that were stable before the edge
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			levels.check_beat(m_axis_tdata);
	end

	// Watchdog: any beat or register access clears the quiet counter
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[%0t] no beat for %0d cycles, giving up", $time, QUIET_LIMIT);
			$display("** batched_servo_pulse_generator_unit: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// Present one item and hold it until the block takes it. tvalid stays high
	// into the next item unless a hold-off is rolled, so back-to-back beats
	// never see tvalid dropped and raised in the same step.
	task automatic send_item(input servo_item_t it);
		if ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= it.opcode;
		s_axis_tdata  <= {7'd0, it.active, it.pulse_width, it.servo_index};
		do @(posedge clk); while (!s_axis_tready);
		levels.note_item(it);
	endtask

	// Drop tvalid, wait for every expected beat, then allow the pipeline to
	// settle before touching the register
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (levels.pending_levels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the write lands at the access edge
	task automatic write_period(input logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_PERIOD, 2'b00};
		pwdata  <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		levels.set_period(value);
	endtask

	function automatic servo_item_t make_item(logic [OPCODE_W-1:0] op, int idx, int w, bit act);
		servo_item_t it;
		it.opcode      = op;
		it.servo_index = idx[IDX_W-1:0];
		it.pulse_width = w[WIDTH_W-1:0];
		it.active      = act;
		return it;
	endfunction

	// Mostly ticks with width writes sprinkled in, and run commands biased to
	// start so that long running stretches form; unused fields carry noise
	function automatic servo_item_t random_item();
		servo_item_t it;
		int pick;
		int cap;
		it.opcode      = OP_TICK;
		it.servo_index = IDX_W'($urandom_range(0, 255));
		it.pulse_width = WIDTH_W'($urandom_range(0, 65535));
		it.active      = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			it.opcode = OP_TICK;
		end else if (pick < 83) begin
			it.opcode = OP_WRITE;
			if ($urandom_range(0, 9) != 0)
				it.servo_index = IDX_W'($urandom_range(0, SERVOS - 1));
			// Keep most widths near the period so compares actually hit
			cap = (levels.period_ticks > 62) ? 64 : levels.period_ticks + 2;
			if ($urandom_range(0, 7) != 0)
				it.pulse_width = WIDTH_W'($urandom_range(0, cap));
		end else if (pick < 95) begin
			it.opcode = OP_ACTIVE;
			it.active = ($urandom_range(0, 3) != 0);
		end else begin
			it.opcode = OP_SPARE;
		end
		return it;
	endfunction

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		levels = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with a short slot so each batch shows up quickly
		write_period(16'd4);
		send_item(make_item(OP_TICK,   0, 0, 1'b1));        // tick while halted
		send_item(make_item(OP_ACTIVE, 0, 0, 1'b0));        // stop while halted
		send_item(make_item(OP_SPARE,  255, 65535, 1'b1));  // spare opcode
		send_item(make_item(OP_WRITE,  0, 2, 1'b0));
		send_item(make_item(OP_WRITE,  1, 0, 1'b0));        // zero width stays low
		send_item(make_item(OP_WRITE,  2, 4, 1'b0));        // width equals period
		send_item(make_item(OP_WRITE,  3, 65535, 1'b0));    // widest pulse
		send_item(make_item(OP_WRITE,  11, 3, 1'b0));
		send_item(make_item(OP_WRITE,  12, 7, 1'b0));       // index past the table
		send_item(make_item(OP_WRITE,  255, 65535, 1'b0));
		send_item(make_item(OP_ACTIVE, 0, 0, 1'b1));
		send_item(make_item(OP_ACTIVE, 0, 0, 1'b1));        // start while running
		repeat (4) send_item(make_item(OP_TICK, 0, 0, 1'b0));
		send_item(make_item(OP_WRITE,  0, 3, 1'b1));        // write while running
		repeat (6) send_item(make_item(OP_TICK, 0, 0, 1'b0));
		send_item(make_item(OP_SPARE,  0, 0, 1'b0));
		send_item(make_item(OP_ACTIVE, 0, 0, 1'b0));        // stop: all pins drop

		// Random phases: new period each time, idling pattern rotates through
		// none, sender only, receiver only, both
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_results();
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 78; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 78; end
				default: begin idle_pct = 25; stall_pct = 25; end
			endcase
			write_period(PERIOD_PLAN[p][15:0]);
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_item(random_item());
		end

		drain_results();
		repeat (8) @(posedge clk);

		$display("Run covered %0d items and %0d result beats over %0d period settings",
			levels.items_taken, levels.beats_checked, NUM_PHASES + 1);
		$display("  %0d running ticks, %0d batch changes, %0d pulse ends, %0d mismatches",
			levels.running_ticks, levels.batch_changes, levels.pin_falls, levels.mismatches);
		if (levels.mismatches == 0)
			$display("** batched_servo_pulse_generator_unit: PASSED **");
		else
			$display("** batched_servo_pulse_generator_unit: FAILED **");
		$finish;
	end

endmodule

// ----- batched_servo_pulse_generator_unit.f -----
sv/bsp_pkg.sv
sv/bsp_width_ram.sv
sv/batched_servo_pulse_generator_unit.sv
sv/bsp_checker.sv
tb/batched_servo_pulse_generator_unit_tb.sv
